// ===== src/ulc_pkg.sv =====
package ulc_pkg;

  localparam int SCORE_BITS = 24;
  localparam int CP_BITS    = 21;

  localparam int FIFO_PTR_BITS = 1;
  localparam int FIFO_DEPTH    = 1 << FIFO_PTR_BITS;
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  localparam logic [7:0] LEAD_TWO_MIN   = 8'h80;
  localparam logic [7:0] LEAD_THREE_MIN = 8'hE0;
  localparam logic [7:0] LEAD_FOUR_MIN  = 8'hF0;
  localparam logic [7:0] CONT_MASK      = 8'h3F;

  localparam logic [CP_BITS-1:0] CP_KANA_LO   = 21'h03040;
  localparam logic [CP_BITS-1:0] CP_KANA_HI   = 21'h030FF;
  localparam logic [CP_BITS-1:0] CP_HANGUL_LO = 21'h0AC00;
  localparam logic [CP_BITS-1:0] CP_HANGUL_HI = 21'h0D7AF;
  localparam logic [CP_BITS-1:0] CP_JAMO_LO   = 21'h01100;
  localparam logic [CP_BITS-1:0] CP_JAMO_HI   = 21'h011FF;
  localparam logic [CP_BITS-1:0] CP_CJK_LO    = 21'h04E00;
  localparam logic [CP_BITS-1:0] CP_CJK_HI    = 21'h09FFF;
  localparam logic [CP_BITS-1:0] CP_CJKA_LO   = 21'h03400;
  localparam logic [CP_BITS-1:0] CP_CJKA_HI   = 21'h04DBF;
  localparam logic [CP_BITS-1:0] CP_CJKB_LO   = 21'h20000;
  localparam logic [CP_BITS-1:0] CP_CJKB_HI   = 21'h2A6DF;
  localparam logic [CP_BITS-1:0] CP_BOPO_M_LO = 21'h002EA;
  localparam logic [CP_BITS-1:0] CP_BOPO_M_HI = 21'h002EB;
  localparam logic [CP_BITS-1:0] CP_BOPO_LO   = 21'h03100;
  localparam logic [CP_BITS-1:0] CP_BOPO_HI   = 21'h0312F;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_JP3,
    KIND_KO3,
    KIND_ZH1,
    KIND_ZH3
  } kind_t;

  typedef enum logic [2:0] {
    LANG_EN    = 3'd0,
    LANG_JA    = 3'd1,
    LANG_KO    = 3'd2,
    LANG_ZH    = 3'd3,
    LANG_OTHER = 3'd4
  } lang_t;

  typedef struct packed {
    kind_t kind;
    logic  last;
  } evt_t;

  function automatic kind_t classify(input logic [CP_BITS-1:0] cp);
    kind_t k;
    k = KIND_NONE;
    if (cp inside {[CP_KANA_LO:CP_KANA_HI]}) begin
      k = KIND_JP3;
    end else if (cp inside {[CP_HANGUL_LO:CP_HANGUL_HI], [CP_JAMO_LO:CP_JAMO_HI]}) begin
      k = KIND_KO3;
    end else if (cp inside {[CP_CJK_LO:CP_CJK_HI], [CP_CJKA_LO:CP_CJKA_HI],
                            [CP_CJKB_LO:CP_CJKB_HI]}) begin
      k = KIND_ZH1;
    end else if (cp inside {[CP_BOPO_M_LO:CP_BOPO_M_HI], [CP_BOPO_LO:CP_BOPO_HI]}) begin
      k = KIND_ZH3;
    end
    return k;
  endfunction

endpackage

// ===== src/ulc_in_if.sv =====
interface ulc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, output text_byte, output byte_present,
                  output end_of_text, input ready);
  modport sink (input valid, input text_byte, input byte_present,
                input end_of_text, output ready);
endinterface

// ===== src/ulc_out_if.sv =====
interface ulc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] language;

  modport source (output valid, output language, input ready);
  modport sink (input valid, input language, output ready);
endinterface

// ===== src/ulc_front.sv =====
module ulc_front (
  input  logic          clk,
  input  logic          rst_n,
  ulc_in_if.sink        in_ch,
  output logic          push,
  output ulc_pkg::evt_t push_data,
  input  logic          full
);
  import ulc_pkg::*;

  logic [1:0]         exp_r, exp_nxt;
  logic [CP_BITS-1:0] cp_r, cp_nxt;
  logic [CP_BITS-1:0] merged;
  logic [CP_BITS-1:0] done_cp;
  logic               done;
  logic               accept;
  logic [7:0]         c;
  kind_t              kind;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.text_byte;

  always_comb begin
    case (exp_r)
      2'd1:    merged = cp_r | {15'b0, c[5:0]};
      2'd2:    merged = cp_r | {9'b0, c[5:0], 6'b0};
      2'd3:    merged = cp_r | {3'b0, c[5:0], 12'b0};
      default: merged = cp_r;
    endcase
  end

  always_comb begin
    exp_nxt = exp_r;
    cp_nxt  = cp_r;
    done    = 1'b0;
    done_cp = '0;
    if (in_ch.byte_present) begin
      if (exp_r == 2'd0) begin
        if (c < LEAD_TWO_MIN) begin
          done    = 1'b1;
          done_cp = {13'b0, c};
        end else if (c < LEAD_THREE_MIN) begin
          cp_nxt  = {10'b0, c[4:0], 6'b0};
          exp_nxt = 2'd1;
        end else if (c < LEAD_FOUR_MIN) begin
          cp_nxt  = {5'b0, c[3:0], 12'b0};
          exp_nxt = 2'd2;
        end else begin
          cp_nxt  = {c[2:0], 18'b0};
          exp_nxt = 2'd3;
        end
      end else begin
        exp_nxt = exp_r - 2'd1;
        if (exp_nxt == 2'd0) begin
          done    = 1'b1;
          done_cp = merged;
          cp_nxt  = '0;
        end else begin
          cp_nxt = merged;
        end
      end
    end
    // score a cut-short sequence with its missing bits as zero
    if (in_ch.end_of_text) begin
      if (exp_nxt != 2'd0) begin
        done    = 1'b1;
        done_cp = cp_nxt;
      end
      exp_nxt = 2'd0;
      cp_nxt  = '0;
    end
  end

  assign kind           = done ? classify(done_cp) : KIND_NONE;
  assign push           = accept && (kind != KIND_NONE || in_ch.end_of_text);
  assign push_data.kind = kind;
  assign push_data.last = in_ch.end_of_text;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
      cp_r  <= '0;
    end else if (accept) begin
      exp_r <= exp_nxt;
      cp_r  <= cp_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_text) |=> (exp_r == 2'd0 && cp_r == '0))
    else $error("decoder state not cleared after final beat");

endmodule

// ===== src/ulc_fifo.sv =====
module ulc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ulc_pkg::evt_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output ulc_pkg::evt_t head_data
);
  import ulc_pkg::*;

  evt_t                     mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_BITS-1:0] count_r;
  logic                     do_push;

  assign full       = (count_r == FIFO_CNT_BITS'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== src/ulc_back.sv =====
module ulc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  ulc_pkg::evt_t head_data,
  output logic          pop,
  ulc_out_if.source     out_ch
);
  import ulc_pkg::*;

  logic [SCORE_BITS-1:0] jp_r, jp_nxt, ko_r, ko_nxt, zh_r, zh_nxt;
  logic [SCORE_BITS-1:0] jp_upd, ko_upd, zh_upd;
  logic                  out_valid_r, out_valid_nxt;
  lang_t                 lang_r, lang_nxt;

  function automatic logic [SCORE_BITS-1:0] sat_add(input logic [SCORE_BITS-1:0] s,
                                                    input logic [1:0] inc);
    logic [SCORE_BITS:0] sum;
    sum = {1'b0, s} + {{(SCORE_BITS-1){1'b0}}, inc};
    return sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];
  endfunction

  function automatic lang_t decide(input logic [SCORE_BITS-1:0] j,
                                   input logic [SCORE_BITS-1:0] k,
                                   input logic [SCORE_BITS-1:0] h);
    lang_t l;
    if (j == '0 && k == '0 && h == '0) begin
      l = LANG_EN;
    end else if (j > k && j > h) begin
      l = LANG_JA;
    end else if (k > j && k > h) begin
      l = LANG_KO;
    end else if (h != '0) begin
      l = LANG_ZH;
    end else begin
      l = LANG_OTHER;
    end
    return l;
  endfunction

  assign pop = head_valid && (!head_data.last || !out_valid_r || out_ch.ready);

  always_comb begin
    jp_upd = jp_r;
    ko_upd = ko_r;
    zh_upd = zh_r;
    case (head_data.kind)
      KIND_JP3: jp_upd = sat_add(jp_r, 2'd3);
      KIND_KO3: ko_upd = sat_add(ko_r, 2'd3);
      KIND_ZH1: zh_upd = sat_add(zh_r, 2'd1);
      KIND_ZH3: zh_upd = sat_add(zh_r, 2'd3);
      default: ;
    endcase
  end

  always_comb begin
    jp_nxt        = jp_r;
    ko_nxt        = ko_r;
    zh_nxt        = zh_r;
    lang_nxt      = lang_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pop) begin
      if (head_data.last) begin
        lang_nxt      = decide(jp_upd, ko_upd, zh_upd);
        out_valid_nxt = 1'b1;
        jp_nxt        = '0;
        ko_nxt        = '0;
        zh_nxt        = '0;
      end else begin
        jp_nxt = jp_upd;
        ko_nxt = ko_upd;
        zh_nxt = zh_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jp_r        <= '0;
      ko_r        <= '0;
      zh_r        <= '0;
      out_valid_r <= 1'b0;
      lang_r      <= LANG_EN;
    end else begin
      jp_r        <= jp_nxt;
      ko_r        <= ko_nxt;
      zh_r        <= zh_nxt;
      out_valid_r <= out_valid_nxt;
      lang_r      <= lang_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.language = lang_r;

  a_scores_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_data.last) |=> (jp_r == '0 && ko_r == '0 && zh_r == '0 && out_valid_r))
    else $error("scores not cleared or result not raised after final beat");

endmodule

// ===== src/utf8_script_language_classifier.sv =====
// UTF-8 script classifier: takes one text byte per beat and returns one language code
// (0 english, 1 japanese, 2 korean, 3 chinese, 4 other) for each beat marked end_of_text.
// A byte is accepted every cycle while the two-entry event queue between the decoder
// and the scorer has room; the decoder and range compares act on each byte as it is
// taken, and the scorer retires one event per cycle unless a held result stalls it.
// The final beat's event is queued, then popped by the scorer into the output register;
// only a result held by a stalled consumer backs the queue up and lowers in_ch.ready.
module utf8_script_language_classifier (
  input  logic      clk,
  input  logic      rst_n,
  ulc_in_if.sink    in_ch,
  ulc_out_if.source out_ch
);
  import ulc_pkg::*;

  logic push, full, pop, head_valid;
  evt_t push_data, head_data;

  ulc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ulc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  ulc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
